// ----- hw/rtl/f2s24_pkg.sv -----
// Package with constants shared by the float to 24-bit PCM converter.
`timescale 1ns / 1ps
package f2s24_pkg;
  localparam int unsigned ExpBias = 127;
  localparam logic [7:0] ExpMax = 8'hFF;
  localparam logic [24:0] PosLimit = 25'd8388607;
  localparam logic [24:0] NegLimit = 25'd8388608;
endpackage

// ----- hw/rtl/float32_to_s24le_converter_unit.sv -----
// Float32 audio sample to signed 24-bit little-endian PCM converter.
// Each request moves from the input register to the result register, and a new
// request is accepted every cycle while stall_o is low. The sample is scaled by
// 2^23, NaN becomes zero, the value is clamped to the 24-bit range and rounded
// to nearest, ties to even.
`timescale 1ns / 1ps
module float32_to_s24le_converter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [31:0] float_bits_i,
  input  logic        last_sample_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [7:0]  byte_low_o,
  output logic [7:0]  byte_mid_o,
  output logic [7:0]  byte_high_o,
  output logic        last_out_o
);
  import f2s24_pkg::*;

  logic        in_vld_q;
  logic [31:0] bits_q;
  logic        last_q;
  logic        out_vld_q;
  logic [23:0] value_q;
  logic        olast_q;
  logic        adv_out;
  logic        adv_in;

  // The output register loads whenever it is empty or being taken.
  assign adv_out = !out_vld_q || !stall_i;
  assign adv_in  = !in_vld_q || adv_out;
  assign stall_o = !adv_in;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (adv_in) begin
      in_vld_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_in && valid_i) begin
      bits_q <= float_bits_i;
      last_q <= last_sample_i;
    end
  end

  // Conversion logic.
  logic        neg;
  logic [7:0]  expo;
  logic [23:0] m;
  logic [4:0]  k;
  logic [23:0] q;
  logic [23:0] rem;
  logic [23:0] half;
  logic [24:0] mag;
  logic [24:0] clamped;
  logic [23:0] value_d;

  always_comb begin
    neg  = bits_q[31];
    expo = bits_q[30:23];
    m    = (expo == 8'd0) ? {1'b0, bits_q[22:0]} : {1'b1, bits_q[22:0]};
    k    = 5'd0;
    q    = 24'd0;
    rem  = 24'd0;
    half = 24'd0;
    mag  = 25'd0;
    if (expo == ExpMax) begin
      mag = (bits_q[22:0] != 23'd0) ? 25'd0 : {1'b1, 24'd0};
    end else if (expo > 8'(ExpBias)) begin
      mag = {1'b1, 24'd0};
    end else if (expo == 8'(ExpBias)) begin
      mag = {1'b0, m};
    end else if (expo == 8'd0) begin
      mag = 25'd0;
    end else if ((8'(ExpBias) - expo) >= 8'd25) begin
      // Scaled magnitude is below one half.
      mag = 25'd0;
    end else begin
      k    = 5'(8'(ExpBias) - expo);
      q    = m >> k;
      rem  = m & ((24'd1 << k) - 24'd1);
      half = 24'd1 << (k - 5'd1);
      mag  = {1'b0, q};
      if (rem > half || (rem == half && q[0])) begin
        mag = {1'b0, q} + 25'd1;
      end
    end
    if (neg) begin
      clamped = (mag > NegLimit) ? NegLimit : mag;
      value_d = 24'(25'h1000000 - clamped);
    end else begin
      clamped = (mag > PosLimit) ? PosLimit : mag;
      value_d = clamped[23:0];
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv_out) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_out && in_vld_q) begin
      value_q <= value_d;
      olast_q <= last_q;
    end
  end

  assign valid_o     = out_vld_q;
  assign byte_low_o  = value_q[7:0];
  assign byte_mid_o  = value_q[15:8];
  assign byte_high_o = value_q[23:16];
  assign last_out_o  = olast_q;

  // A stalled result stays in place.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(value_q))
    else $error("result changed while stalled");

  // A request held in the input register is never dropped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !adv_out |=> in_vld_q && $stable(bits_q))
    else $error("input request lost");

  // Input is stalled only while both registers are full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |-> in_vld_q && out_vld_q && stall_i)
    else $error("needless input stall");
endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the float32 to signed 24-bit PCM converter.
`timescale 1ns / 1ps
module testbench;
  import f2s24_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        stall_o;
  logic [31:0] float_bits_i = '0;
  logic        last_sample_i = 1'b0;
  logic        valid_o;
  logic        stall_i = 1'b0;
  logic [7:0]  byte_low_o;
  logic [7:0]  byte_mid_o;
  logic [7:0]  byte_high_o;
  logic        last_out_o;

  typedef struct packed {
    logic [23:0] pcm;
    logic        last;
  } pcm_sample_t;

  typedef struct packed {
    logic [31:0] bits;
    logic        check_fixed;
    logic [23:0] fixed_pcm;
  } sample_row_t;

  localparam int unsigned NumRandom = 1500;
  localparam int unsigned CycleLimit = 200000;

  pcm_sample_t pending_pcm[$];
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;
  bit          hold_long = 1'b0;
  bit          stim_done = 1'b0;
  sample_row_t sample_rows[$];

  float32_to_s24le_converter_unit dut (.*);

  always #2ns clk_i = ~clk_i;

  // Rounded, clamped PCM value of a float bit pattern.
  function automatic logic [23:0] float_to_pcm(logic [31:0] bits);
    logic [7:0]  expo;
    logic [23:0] man;
    logic [31:0] mag;
    logic [31:0] rem;
    logic [31:0] half;
    int          shift;
    expo = bits[30:23];
    man = (expo == 8'd0) ? {1'b0, bits[22:0]} : {1'b1, bits[22:0]};
    shift = int'(ExpBias) - ((expo == 8'd0) ? 1 : int'(expo));
    if (expo == ExpMax) begin
      mag = (bits[22:0] != 0) ? 32'd0 : 32'hFFFF_FFFF;
    end else if (shift < 0) begin
      mag = 32'hFFFF_FFFF;
    end else if (shift == 0) begin
      mag = 32'(man);
    end else if (shift >= 26) begin
      mag = 32'd0;
    end else begin
      mag = 32'(man) >> shift;
      rem = 32'(man) & ((32'd1 << shift) - 1);
      half = 32'd1 << (shift - 1);
      if (rem > half || (rem == half && mag[0])) mag = mag + 1;
    end
    if (bits[31]) begin
      if (mag > 32'(NegLimit)) mag = 32'(NegLimit);
      return 24'(32'h0100_0000 - mag);
    end
    if (mag > 32'(PosLimit)) mag = 32'(PosLimit);
    return mag[23:0];
  endfunction

  // Sends one request after a random gap and records its expected sample.
  task automatic send_sample(logic [31:0] bits, logic last, bit fixed, logic [23:0] pcm);
    int unsigned gap;
    pcm_sample_t exp_s;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    if (gap != 0) valid_i <= 1'b0;
    repeat (gap) @(posedge clk_i);
    valid_i <= 1'b1;
    float_bits_i <= bits;
    last_sample_i <= last;
    exp_s.pcm = fixed ? pcm : float_to_pcm(bits);
    exp_s.last = last;
    if (fixed && pcm != float_to_pcm(bits)) begin
      $error("table row %h: typed %h, predicted %h", bits, pcm, float_to_pcm(bits));
      fail_count++;
    end
    do @(posedge clk_i); while (stall_o);
    pending_pcm.push_back(exp_s);
  endtask

  // Random pattern biased toward audio range, edges and specials.
  function automatic logic [31:0] random_bits();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 5))
      0, 1: r[30:23] = 8'($urandom_range(100, 126));
      2: r[30:23] = 8'($urandom_range(126, 128));
      3: r[30:23] = ($urandom_range(0, 1)) ? ExpMax : 8'd0;
      default: ;
    endcase
    return r;
  endfunction

  // Stimulus: directed table, pauses and random samples.
  initial begin
    sample_rows = '{
      '{32'h0000_0000, 1'b1, 24'h000000}, '{32'h8000_0000, 1'b1, 24'h000000},
      '{32'h3F80_0000, 1'b1, 24'h7FFFFF}, '{32'hBF80_0000, 1'b1, 24'h800000},
      '{32'h7F80_0000, 1'b1, 24'h7FFFFF}, '{32'hFF80_0000, 1'b1, 24'h800000},
      '{32'h7FC0_0000, 1'b1, 24'h000000}, '{32'hFF80_0001, 1'b1, 24'h000000},
      '{32'h7FFF_FFFF, 1'b1, 24'h000000}, '{32'h0000_0001, 1'b1, 24'h000000},
      '{32'h807F_FFFF, 1'b1, 24'h000000}, '{32'h3F7F_FFFF, 1'b1, 24'h7FFFFF},
      '{32'h7F7F_FFFF, 1'b1, 24'h7FFFFF}, '{32'hFF7F_FFFF, 1'b1, 24'h800000},
      '{32'h3F00_0000, 1'b1, 24'h400000}, '{32'h3380_0000, 1'b1, 24'h000000},
      '{32'h3440_0000, 1'b1, 24'h000002}, '{32'h34A0_0000, 1'b1, 24'h000002},
      '{32'hB4A0_0000, 1'b1, 24'hFFFFFE}, '{32'h3480_0000, 1'b1, 24'h000002},
      '{32'h3E80_0001, 1'b0, 24'h0}, '{32'hBF3F_FFFF, 1'b0, 24'h0},
      '{32'h4000_0000, 1'b1, 24'h7FFFFF}, '{32'hC000_0000, 1'b1, 24'h800000}
    };
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (sample_rows[i]) begin
      send_sample(sample_rows[i].bits, 1'($urandom_range(0, 1)),
                  sample_rows[i].check_fixed, sample_rows[i].fixed_pcm);
    end
    valid_i <= 1'b0;
    // Sender pauses until the block has drained.
    while (pending_pcm.size() != 0) @(posedge clk_i);
    for (int unsigned n = 0; n < NumRandom; n++) begin
      if (n == NumRandom / 2) hold_long = 1'b1;
      send_sample(random_bits(), 1'($urandom_range(0, 1)), 1'b0, 24'h0);
    end
    valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  // Receiver stalls, with one long hold-off while the sender keeps going.
  initial begin
    int unsigned wait_cycles;
    forever begin
      @(posedge clk_i);
      if (hold_long) begin
        stall_i <= 1'b1;
        repeat (60) @(posedge clk_i);
        hold_long = 1'b0;
        stall_i <= 1'b0;
      end else if (valid_o && !stall_i) begin
        wait_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 14);
        if (wait_cycles != 0) begin
          stall_i <= 1'b1;
          repeat (wait_cycles) @(posedge clk_i);
          stall_i <= 1'b0;
        end
      end
    end
  end

  // Compares each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    pcm_sample_t exp_s;
    if (rst_ni && valid_o && !stall_i) begin
      if (pending_pcm.size() == 0) begin
        $error("result with no request outstanding");
        fail_count++;
      end else begin
        exp_s = pending_pcm.pop_front();
        if (byte_low_o !== exp_s.pcm[7:0]) begin
          $error("byte_low: expected %h, got %h", exp_s.pcm[7:0], byte_low_o);
          fail_count++;
        end
        if (byte_mid_o !== exp_s.pcm[15:8]) begin
          $error("byte_mid: expected %h, got %h", exp_s.pcm[15:8], byte_mid_o);
          fail_count++;
        end
        if (byte_high_o !== exp_s.pcm[23:16]) begin
          $error("byte_high: expected %h, got %h", exp_s.pcm[23:16], byte_high_o);
          fail_count++;
        end
        if (last_out_o !== exp_s.last) begin
          $error("last_out: expected %b, got %b", exp_s.last, last_out_o);
          fail_count++;
        end
      end
    end
  end

  // Ends the run after the drain, or on timeout.
  initial begin
    while (!(stim_done && pending_pcm.size() == 0) && cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    if (cycle_count >= CycleLimit) begin
      $display("float32_to_s24le_converter_unit verification failed");
    end else begin
      repeat (10) @(posedge clk_i);
      if (fail_count == 0) begin
        $display("float32_to_s24le_converter_unit verification clean");
      end else begin
        $display("float32_to_s24le_converter_unit verification failed");
      end
    end
    $finish;
  end
endmodule
